/* rtl/scf_pkg.sv */
// Shared types, command codes and the frame layout function for the servo
// command frame builder. Used by every module in rtl/; depends on nothing.
package scf_pkg;

	localparam int NumCells   = 18;
	localparam int HeadBytes  = 5;
	localparam int PayloadMax = 12;
	localparam int CfgIdxW    = 1;

	// request modes
	localparam logic [3:0] MODE_OFF     = 4'd0;
	localparam logic [3:0] MODE_STOP    = 4'd1;
	localparam logic [3:0] MODE_RUN     = 4'd2;
	localparam logic [3:0] MODE_SETZERO = 4'd3;
	localparam logic [3:0] MODE_READENC = 4'd4;
	localparam logic [3:0] MODE_TORQUE  = 4'd5;
	localparam logic [3:0] MODE_SPEED   = 4'd6;
	localparam logic [3:0] MODE_POS1    = 4'd7;
	localparam logic [3:0] MODE_POS2    = 4'd8;
	localparam logic [3:0] MODE_POS3    = 4'd9;
	localparam logic [3:0] MODE_POS4    = 4'd10;

	// command codes on the wire
	localparam logic [7:0] CMD_OFF     = 8'h80;
	localparam logic [7:0] CMD_STOP    = 8'h81;
	localparam logic [7:0] CMD_RUN     = 8'h88;
	localparam logic [7:0] CMD_SETZERO = 8'h19;
	localparam logic [7:0] CMD_READENC = 8'h90;
	localparam logic [7:0] CMD_TORQUE  = 8'hA1;
	localparam logic [7:0] CMD_SPEED   = 8'hA2;
	localparam logic [7:0] CMD_POS1    = 8'hA3;
	localparam logic [7:0] CMD_POS2    = 8'hA4;
	localparam logic [7:0] CMD_POS3    = 8'hA5;
	localparam logic [7:0] CMD_POS4    = 8'hA6;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_HEADER   = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_MOTOR_ID = 1'b1;

	// one byte slot of the output chain; a sum slot sends the running checksum
	typedef struct packed {
		logic       vld;
		logic       is_sum;
		logic       lst;
		logic [7:0] data;
	} scf_cell_t;

	typedef scf_cell_t [NumCells-1:0] scf_row_t;

	// scaled request held in the input stage
	typedef struct packed {
		logic [3:0]  mode;
		logic [63:0] ang;
		logic [31:0] spd;
		logic [31:0] spd100;
		logic [15:0] trq;
		logic [7:0]  dir;
	} scf_req_t;

	function automatic logic mode_ok(input logic [3:0] m);
		return m <= MODE_POS4;
	endfunction

	function automatic scf_row_t frame_row(input scf_req_t req, input logic [7:0] hdr,
		input logic [7:0] id);
		logic [7:0]                  code;
		logic [7:0]                  len;
		logic [PayloadMax-1:0][7:0]  pl;
		scf_row_t                    row;
		unique case (req.mode)
			MODE_OFF:     begin code = CMD_OFF;     len = 8'd0;  end
			MODE_STOP:    begin code = CMD_STOP;    len = 8'd0;  end
			MODE_RUN:     begin code = CMD_RUN;     len = 8'd0;  end
			MODE_SETZERO: begin code = CMD_SETZERO; len = 8'd0;  end
			MODE_READENC: begin code = CMD_READENC; len = 8'd0;  end
			MODE_TORQUE:  begin code = CMD_TORQUE;  len = 8'd2;  end
			MODE_SPEED:   begin code = CMD_SPEED;   len = 8'd4;  end
			MODE_POS1:    begin code = CMD_POS1;    len = 8'd8;  end
			MODE_POS2:    begin code = CMD_POS2;    len = 8'd12; end
			MODE_POS3:    begin code = CMD_POS3;    len = 8'd4;  end
			MODE_POS4:    begin code = CMD_POS4;    len = 8'd8;  end
			default:      begin code = 8'd0;        len = 8'd0;  end
		endcase
		pl = '0;
		case (req.mode)
			MODE_TORQUE: pl[1:0] = req.trq;
			MODE_SPEED:  pl[3:0] = req.spd;
			MODE_POS1:   pl[7:0] = req.ang;
			MODE_POS2: begin
				pl[7:0]  = req.ang;
				pl[11:8] = req.spd100;
			end
			MODE_POS3: begin
				pl[0]   = req.dir;
				pl[3:1] = req.ang[23:0];
			end
			MODE_POS4: begin
				pl[0]   = req.dir;
				pl[3:1] = req.ang[23:0];
				pl[7:4] = req.spd100;
			end
			default: pl = '0;
		endcase
		row = '0;
		row[0] = '{vld: 1'b1, is_sum: 1'b0, lst: 1'b0, data: hdr};
		row[1] = '{vld: 1'b1, is_sum: 1'b0, lst: 1'b0, data: code};
		row[2] = '{vld: 1'b1, is_sum: 1'b0, lst: 1'b0, data: id};
		row[3] = '{vld: 1'b1, is_sum: 1'b0, lst: 1'b0, data: len};
		row[4] = '{vld: 1'b1, is_sum: 1'b1, lst: (len == 8'd0), data: 8'd0};
		for (int k = 0; k < PayloadMax; k++) begin
			if (k < int'(len))
				row[HeadBytes+k] = '{vld: 1'b1, is_sum: 1'b0, lst: 1'b0, data: pl[k]};
		end
		for (int j = 1; j <= PayloadMax; j++) begin
			if (j == int'(len))
				row[HeadBytes+j] = '{vld: 1'b1, is_sum: 1'b1, lst: 1'b1, data: 8'd0};
		end
		return row;
	endfunction

endpackage

/* rtl/scf_prep.sv */
// Input stage: registers one request and scales angle and speed by 100.
// Depends on scf_pkg.
module scf_prep import scf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [3:0]        mode,
	input  logic [63:0]       position_value,
	input  logic signed [31:0] speed_value,
	input  logic [15:0]       torque_value,
	input  logic [7:0]        direction_byte,
	input  logic              drain,
	output logic              vld,
	output scf_req_t          req
);

	logic     vld_s1;
	scf_req_t req_s1;
	logic     take;

	assign in_ready = !vld_s1 || drain;
	assign take     = in_valid && in_ready;
	assign vld      = vld_s1;
	assign req      = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (drain) begin
			vld_s1 <= 1'b0;
		end
	end

	// times 100 as 64 + 32 + 4, wrapping at the field width
	always_ff @(posedge clk) begin
		if (take) begin
			req_s1.mode   <= mode;
			req_s1.ang    <= (position_value << 6) + (position_value << 5)
				+ (position_value << 2);
			req_s1.spd    <= speed_value;
			req_s1.spd100 <= (speed_value << 6) + (speed_value << 5) + (speed_value << 2);
			req_s1.trq    <= torque_value;
			req_s1.dir    <= direction_byte;
		end
	end

endmodule

/* rtl/scf_cell.sv */
// One byte slot of the output shift chain: loads in parallel, shifts toward
// the output otherwise. Depends on scf_pkg.
module scf_cell import scf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  logic      shift,
	input  scf_cell_t load_val,
	input  scf_cell_t next_val,
	output scf_cell_t q
);

	scf_cell_t cell_q;

	assign q = cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (load) begin
			cell_q <= load_val;
		end else if (shift) begin
			cell_q <= next_val;
		end
	end

endmodule

/* rtl/servo_command_frame_builder.sv */
// Servo command frame builder. A request is registered in the input stage,
// then its whole frame loads into a chain of 18 byte cells and leaves one byte
// per cycle from the head cell while out_ready is high. Frames are 5, 8, 10, 14
// or 18 bytes (18 for position mode 2). The next frame loads on the cycle its
// predecessor's last byte is taken, so frames follow without a gap. A request
// passes the input stage register, then the head cell, before its first byte
// shows. Checksums are summed as bytes leave the head cell. Modes 11 to 15 are
// taken and dropped with no output. Depends on scf_pkg, scf_prep and scf_cell.
module servo_command_frame_builder import scf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0]          mode,
	input  logic [63:0]         position_value,
	input  logic signed [31:0]  speed_value,
	input  logic [15:0]         torque_value,
	input  logic [7:0]          direction_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          frame_byte,
	output logic                last_byte,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [7:0]          cfg_data
);

	logic [7:0]          header_q;
	logic [7:0]          id_q;
	logic [7:0]          acc_q;
	logic                req_vld;
	scf_req_t            req;
	logic                drain;
	logic                load_ok;
	logic                load;
	logic                shift;
	scf_row_t            row;
	scf_cell_t           cells [NumCells];
	logic [NumCells-1:0] vld_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= 8'd62;
			id_q     <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER:   header_q <= cfg_data;
				REG_MOTOR_ID: id_q     <= cfg_data;
				default:      header_q <= header_q;
			endcase
		end
	end

	scf_prep u_prep (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.position_value (position_value),
		.speed_value    (speed_value),
		.torque_value   (torque_value),
		.direction_byte (direction_byte),
		.drain          (drain),
		.vld            (req_vld),
		.req            (req)
	);

	// chain is free once at most the head cell holds a byte and it leaves now
	assign shift   = out_valid && out_ready;
	assign load_ok = !cells[0].vld || (!cells[1].vld && out_ready);
	assign load    = req_vld && mode_ok(req.mode) && load_ok;
	assign drain   = req_vld && (load_ok || !mode_ok(req.mode));
	assign row     = frame_row(req, header_q, id_q);

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		scf_cell_t next_val;
		if (i == NumCells - 1) begin : g_tail
			assign next_val = '0;
		end else begin : g_mid
			assign next_val = cells[i+1];
		end
		scf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (load),
			.shift    (shift),
			.load_val (row[i]),
			.next_val (next_val),
			.q        (cells[i])
		);
		assign vld_vec[i] = cells[i].vld;
	end

	// running checksum: add data bytes, clear after each sum byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 8'd0;
		end else if (shift) begin
			acc_q <= cells[0].is_sum ? 8'd0 : acc_q + cells[0].data;
		end
	end

	assign out_valid  = cells[0].vld;
	assign frame_byte = cells[0].is_sum ? acc_q : cells[0].data;
	assign last_byte  = cells[0].lst;

	a_vld_contig: assert property (@(posedge clk) disable iff (!arst_n)
		((NumCells'(vld_vec + 1'b1)) & vld_vec) == '0)
		else $error("chain valid bits not contiguous from the head cell");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !cells[1].vld)
		else $error("frame loaded over a pending frame");

	a_last_is_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(cells[0].vld && cells[0].lst) |-> cells[0].is_sum)
		else $error("frame ends on a byte that is not a checksum");

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(shift && cells[0].lst) |=> (acc_q == 8'd0))
		else $error("checksum not cleared at end of frame");

endmodule
